// ----- hw/rtl/kcv3_pkg.sv -----
// ----------------------------------------------------------------------------
// kcv3_pkg
// Shared types, codes and saturation helpers for the three-axis
// constant-velocity tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package kcv3_pkg;

    // One input item.
    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] meas_x;
        logic signed [31:0] meas_y;
        logic signed [31:0] meas_z;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [47:0] est_x;
        logic signed [47:0] est_y;
        logic signed [47:0] est_z;
        logic signed [47:0] est_vx;
        logic signed [47:0] est_vy;
        logic signed [47:0] est_vz;
        logic [46:0]        var_position;
        logic signed [47:0] cov_pos_vel;
        logic [46:0]        var_velocity;
        logic               saturated;
    } t_out_item;

    // Operation codes. The spare fourth code behaves as predict only.
    localparam logic [1:0] OP_UPDATE  = 2'd0;
    localparam logic [1:0] OP_PREDICT = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_SPARE   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_PROC_NOISE = 2'd0;
    localparam logic [1:0] REG_MEAS_NOISE = 2'd1;
    localparam logic [1:0] REG_INIT_VAR   = 2'd2;

    // Multiply-divide jobs. Jobs below JOB_PP_R are per axis:
    // bits [2:1] give the axis, bit 0 clear is velocity, set is position.
    localparam logic [3:0] JOB_FIRST = 4'd0;
    localparam logic [3:0] JOB_PP_R  = 4'd6;
    localparam logic [3:0] JOB_PV_R  = 4'd7;
    localparam logic [3:0] JOB_PV_PV = 4'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       predict;
        logic       job_start;
        logic       job_write;
        logic [3:0] job;
        logic       out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic update;
        logic job_done;
    } t_stat;

    localparam logic signed [65:0] MAX48 = 66'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [65:0] MIN48 = -66'sh0_8000_0000_0000;

    // Clip to the signed 48-bit range; returns {clipped, value}.
    function automatic logic [48:0] sat48(input logic signed [65:0] v);
        logic [48:0] r;
        if (v > MAX48) begin
            r = {1'b1, 48'h7FFF_FFFF_FFFF};
        end else if (v < MIN48) begin
            r = {1'b1, 48'h8000_0000_0000};
        end else begin
            r = {1'b0, v[47:0]};
        end
        return r;
    endfunction

    // Clip a variance to [0, 2^47-1]; returns {clipped, value}.
    function automatic logic [48:0] sat_var(input logic signed [65:0] v);
        logic [48:0] r;
        if (v > MAX48) begin
            r = {1'b1, 48'h7FFF_FFFF_FFFF};
        end else if (v < 66'sd0) begin
            r = {1'b1, 48'd0};
        end else begin
            r = {1'b0, v[47:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/kcv3_muldiv.sv -----
// ----------------------------------------------------------------------------
// kcv3_muldiv
// Sequential signed multiply then truncating divide: sign(a*b)*|a*b|/d,
// quotient clamped to 2^62, zero when d is zero. Four multiply steps of
// sixteen bits, then one restoring division step per dividend bit.
// ----------------------------------------------------------------------------
`default_nettype none

module kcv3_muldiv
    import kcv3_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [48:0] i_a,
    input  wire logic signed [48:0] i_b,
    input  wire logic [47:0]        i_d,
    output logic                    o_done,
    output logic signed [63:0]      o_q
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    localparam logic [6:0]  MUL_LAST = 7'd3;
    localparam logic [6:0]  DIV_LAST = 7'd97;
    localparam logic [62:0] QCLAMP   = 63'h4000_0000_0000_0000;

    logic [1:0]  r_phase;
    logic [6:0]  r_cnt;
    logic [48:0] r_ua;
    logic [63:0] r_ub;
    logic [97:0] r_acc;
    logic [47:0] r_rem;
    logic [62:0] r_q;
    logic        r_ovf;
    logic        r_neg;
    logic [47:0] r_d;
    logic        r_done;
    logic signed [63:0] r_res;

    logic [48:0] n_ua;
    logic [48:0] n_ub;
    logic [64:0] n_prod;
    logic [48:0] n_rem2;
    logic        n_ge;
    logic [62:0] n_mag;

    // Operand magnitudes and the per-step arithmetic.
    always_comb begin
        n_ua   = i_a[48] ? (~i_a + 49'd1) : i_a;
        n_ub   = i_b[48] ? (~i_b + 49'd1) : i_b;
        n_prod = r_ua * r_ub[63:48];
        n_rem2 = {r_rem, r_acc[97]};
        n_ge   = (n_rem2 >= {1'b0, r_d});
        n_mag  = (r_ovf || (r_q > QCLAMP)) ? QCLAMP : r_q;
    end

    // Phase sequencing and control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= 7'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_phase <= PH_MUL;
                        r_cnt   <= 7'd0;
                    end
                end
                PH_MUL: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == MUL_LAST) begin
                        r_phase <= PH_DIV;
                        r_cnt   <= 7'd0;
                    end
                end
                PH_DIV: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_phase <= PH_FIN;
                    end
                end
                PH_FIN: begin
                    r_phase <= PH_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    // Operand and working registers.
    always_ff @(posedge i_clk) begin
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    r_ua  <= n_ua;
                    r_ub  <= {15'd0, n_ub};
                    r_acc <= 98'd0;
                    r_rem <= 48'd0;
                    r_q   <= 63'd0;
                    r_ovf <= 1'b0;
                    r_neg <= i_a[48] ^ i_b[48];
                    r_d   <= i_d;
                end
            end
            PH_MUL: begin
                r_acc <= {r_acc[81:0], 16'd0} + {33'd0, n_prod};
                r_ub  <= {r_ub[47:0], 16'd0};
            end
            PH_DIV: begin
                r_acc <= {r_acc[96:0], 1'b0};
                r_rem <= n_ge ? 48'(n_rem2 - {1'b0, r_d}) : n_rem2[47:0];
                r_ovf <= r_ovf | r_q[62];
                r_q   <= {r_q[61:0], n_ge};
            end
            PH_FIN: begin
                if (r_d == 48'd0) begin
                    r_res <= 64'sd0;
                end else if (r_neg) begin
                    r_res <= -$signed({1'b0, n_mag});
                end else begin
                    r_res <= $signed({1'b0, n_mag});
                end
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_q    = r_res;

endmodule

`default_nettype wire

// ----- hw/rtl/kcv3_dp.sv -----
// ----------------------------------------------------------------------------
// kcv3_dp
// Tracker datapath: configuration, filter state, the predict step, the
// shared multiply-divide unit with its write-back, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kcv3_dp
    import kcv3_pkg::*;
#(
    parameter int FRAC_BITS = 24,
    parameter int NUM_AXES  = 3
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    input  wire t_in_item    i_in_data,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [46:0] i_cfg_wdata,
    output t_out_item        o_out_data
);

    localparam int MSH = FRAC_BITS - 16;
    localparam logic [63:0] Q_RST  = (64'd1 << FRAC_BITS) / 64'd100;
    localparam logic [63:0] R_RST  = 64'd10 << FRAC_BITS;
    localparam logic [63:0] P0_RST = 64'd1000 << FRAC_BITS;

    logic [46:0] r_qn;
    logic [46:0] r_rn;
    logic [46:0] r_p0;

    logic signed [47:0] r_pos  [3];
    logic signed [47:0] r_vel  [3];
    logic signed [47:0] r_meas [3];
    logic signed [47:0] r_pp;
    logic signed [47:0] r_pv;
    logic signed [47:0] r_vv;
    logic signed [47:0] r_wpp;
    logic signed [47:0] r_wpv;
    logic signed [47:0] r_wvv;
    logic [47:0]        r_s;
    logic [1:0]         r_op;
    logic               r_clip;
    t_out_item          r_out;

    logic signed [65:0] n_q66;
    logic [48:0]        n_pp;
    logic [48:0]        n_pv;
    logic [48:0]        n_vv;
    logic [48:0]        n_ppos [3];
    logic [1:0]         n_ax;
    logic signed [48:0] n_y;
    logic signed [48:0] n_a;
    logic signed [48:0] n_b;
    logic               md_done;
    logic signed [63:0] md_q;
    logic [48:0]        n_wb;

    // Predicted covariance and positions.
    always_comb begin
        n_q66 = $signed({19'd0, r_qn});
        n_pp  = sat_var(66'(r_pp) + (66'(r_pv) <<< 1) + 66'(r_vv) + n_q66);
        n_pv  = sat48(66'(r_pv) + 66'(r_vv));
        n_vv  = sat_var(66'(r_vv) + n_q66);
        for (int i = 0; i < 3; i++) begin
            n_ppos[i] = sat48(66'(r_pos[i]) + 66'(r_vel[i]));
        end
    end

    // Operand selection for the multiply-divide unit.
    always_comb begin
        n_ax = i_cmd.job[2:1];
        n_y  = 49'(r_meas[n_ax]) - 49'(r_pos[n_ax]);
        n_a  = 49'(r_wpv);
        n_b  = n_y;
        case (i_cmd.job)
            JOB_PP_R: begin
                n_a = 49'(r_wpp);
                n_b = $signed({2'd0, r_rn});
            end
            JOB_PV_R: begin
                n_a = 49'(r_wpv);
                n_b = $signed({2'd0, r_rn});
            end
            JOB_PV_PV: begin
                n_a = 49'(r_wpv);
                n_b = 49'(r_wpv);
            end
            default: begin
                n_a = i_cmd.job[0] ? 49'(r_wpp) : 49'(r_wpv);
                n_b = n_y;
            end
        endcase
    end

    kcv3_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.job_start),
        .i_a     (n_a),
        .i_b     (n_b),
        .i_d     (r_s),
        .o_done  (md_done),
        .o_q     (md_q)
    );

    // Write-back value of the finished job; saturated except for the two R jobs.
    always_comb begin
        case (i_cmd.job)
            JOB_PP_R:  n_wb = {1'b0, md_q[47:0]};
            JOB_PV_R:  n_wb = {1'b0, md_q[47:0]};
            JOB_PV_PV: n_wb = sat_var(66'(r_wvv) - 66'(md_q));
            default: begin
                if (i_cmd.job[0]) begin
                    n_wb = sat48(66'(r_pos[n_ax]) + 66'(md_q));
                end else begin
                    n_wb = sat48(66'(r_vel[n_ax]) + 66'(md_q));
                end
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qn <= Q_RST[46:0];
            r_rn <= R_RST[46:0];
            r_p0 <= P0_RST[46:0];
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PROC_NOISE: r_qn <= i_cfg_wdata;
                REG_MEAS_NOISE: r_rn <= i_cfg_wdata;
                REG_INIT_VAR:   r_p0 <= i_cfg_wdata;
                default:        r_qn <= r_qn;
            endcase
        end
    end

    // Filter state: restart, predict and job write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= 48'sd0;
                r_vel[i] <= 48'sd0;
            end
            r_pp   <= $signed(P0_RST[47:0]);
            r_pv   <= 48'sd0;
            r_vv   <= $signed(P0_RST[47:0]);
            r_clip <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_clip <= 1'b0;
            end
            if (i_cmd.predict) begin
                if (r_op == OP_RESTART) begin
                    for (int i = 0; i < NUM_AXES; i++) begin
                        r_pos[i] <= r_meas[i];
                        r_vel[i] <= 48'sd0;
                    end
                    r_pp <= $signed({1'b0, r_p0});
                    r_pv <= 48'sd0;
                    r_vv <= $signed({1'b0, r_p0});
                end else begin
                    for (int i = 0; i < NUM_AXES; i++) begin
                        r_pos[i] <= n_ppos[i][47:0];
                    end
                    r_pp   <= n_pp[47:0];
                    r_pv   <= n_pv[47:0];
                    r_vv   <= n_vv[47:0];
                    r_clip <= r_clip | n_pp[48] | n_pv[48] | n_vv[48]
                              | n_ppos[0][48] | n_ppos[1][48] | n_ppos[2][48];
                end
            end
            if (i_cmd.job_write) begin
                r_clip <= r_clip | n_wb[48];
                case (i_cmd.job)
                    JOB_PP_R:  r_pp <= n_wb[47:0];
                    JOB_PV_R:  r_pv <= n_wb[47:0];
                    JOB_PV_PV: r_vv <= n_wb[47:0];
                    default: begin
                        if (i_cmd.job[0]) begin
                            r_pos[n_ax] <= n_wb[47:0];
                        end else begin
                            r_vel[n_ax] <= n_wb[47:0];
                        end
                    end
                endcase
            end
        end
    end

    // Item capture, working copies of the predicted covariance and the innovation variance.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_in_data.operation;
            r_meas[0] <= 48'(i_in_data.meas_x) <<< MSH;
            r_meas[1] <= 48'(i_in_data.meas_y) <<< MSH;
            r_meas[2] <= 48'(i_in_data.meas_z) <<< MSH;
        end
        if (i_cmd.predict) begin
            r_wpp <= n_pp[47:0];
            r_wpv <= n_pv[47:0];
            r_wvv <= n_vv[47:0];
            r_s   <= n_pp[47:0] + {1'b0, r_rn};
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.est_x        <= r_pos[0];
            r_out.est_y        <= r_pos[1];
            r_out.est_z        <= r_pos[2];
            r_out.est_vx       <= r_vel[0];
            r_out.est_vy       <= r_vel[1];
            r_out.est_vz       <= r_vel[2];
            r_out.var_position <= r_pp[46:0];
            r_out.cov_pos_vel  <= r_pv;
            r_out.var_velocity <= r_vv[46:0];
            r_out.saturated    <= r_clip;
        end
    end

    assign o_stat.update   = (r_op == OP_UPDATE);
    assign o_stat.job_done = md_done;
    assign o_out_data      = r_out;

endmodule

`default_nettype wire

// ----- hw/rtl/kcv3_ctrl.sv -----
// ----------------------------------------------------------------------------
// kcv3_ctrl
// Tracker controller: accepts an item, runs the predict step, steps the
// multiply-divide jobs of an update and hands the result to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module kcv3_ctrl
    import kcv3_pkg::*;
#(
    parameter int NUM_AXES = 3
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  wire logic  i_out_stall,
    output t_cmd       o_cmd,
    input  wire t_stat i_stat
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRED  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [3:0] r_job;
    logic [3:0] n_job;
    logic [3:0] n_inc;
    logic       r_out_valid;
    logic       n_load;

    // Next job, skipping the per-axis jobs of unused axes.
    always_comb begin
        n_inc = r_job + 4'd1;
        if ((n_inc < JOB_PP_R) && (int'(n_inc[3:1]) >= NUM_AXES)) begin
            n_inc = JOB_PP_R;
        end
    end

    // State transitions and commands.
    always_comb begin
        n_state         = r_state;
        n_job           = r_job;
        n_load          = 1'b0;
        o_cmd           = '0;
        o_cmd.job       = r_job;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_PRED;
                end
            end
            S_PRED: begin
                o_cmd.predict = 1'b1;
                n_job         = JOB_FIRST;
                n_state       = i_stat.update ? S_START : S_OUT;
            end
            S_START: begin
                o_cmd.job_start = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.job_done) begin
                    o_cmd.job_write = 1'b1;
                    if (r_job == JOB_PV_PV) begin
                        n_state = S_OUT;
                    end else begin
                        n_job   = n_inc;
                        n_state = S_START;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_load         = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= JOB_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // A job only finishes while the controller waits for it.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.job_done |-> (r_state == S_WAIT))
        else $error("multiply-divide finished outside the wait state");

    // The job index stays within the job list.
    a_job_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> (r_job <= JOB_PV_PV))
        else $error("job index out of range");

    // An accepted item goes straight to the predict step.
    a_accept_pred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_PRED))
        else $error("accepted item did not enter the predict step");

    // A result is loaded only when the output register is free.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_load |-> (!r_out_valid || !i_out_stall))
        else $error("result overwrote a pending output");

endmodule

`default_nettype wire

// ----- hw/rtl/kalman_constant_velocity_3d_unit.sv -----
// ----------------------------------------------------------------------------
// kalman_constant_velocity_3d_unit
// Three-axis constant-velocity Kalman tracker, signed fixed point.
// ----------------------------------------------------------------------------
//  channel  | ports                               | transfer when
//  ---------+-------------------------------------+-------------------------
//  input    | i_in_valid, o_in_stall, i_in_data   | valid high, stall low
//  output   | o_out_valid, i_out_stall, o_out_data| valid high, stall low
//  config   | i_cfg_we, i_cfg_index, i_cfg_wdata  | write enable high
//
//  Restart and predict-only items pass from the transfer through the predict
//  and output-load states; the next item can transfer once the controller is
//  idle again. A predict-and-update item runs the predict step, nine jobs on
//  one shared multiply-divide unit (start, four multiply steps, 98 division
//  steps, finish and write-back) and the output load. Reset is synchronous,
//  active low, and restores the configuration and filter state at once. A
//  stalled output holds its result; the next item may be taken meanwhile,
//  but its result waits for the register.
// ----------------------------------------------------------------------------
`default_nettype none

module kalman_constant_velocity_3d_unit
    import kcv3_pkg::*;
#(
    parameter int FRAC_BITS = 24,
    parameter int NUM_AXES  = 3
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [46:0] i_cfg_wdata
);

    t_cmd  cmd;
    t_stat stat;

    kcv3_ctrl #(
        .NUM_AXES (NUM_AXES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    kcv3_dp #(
        .FRAC_BITS (FRAC_BITS),
        .NUM_AXES  (NUM_AXES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
